// ===== rtl/core/aes_pkg.sv =====
// Shared types, tables and round functions for the AES-128 encryption pipeline.
package aes_pkg;

	localparam int NUM_ROUNDS = 10;
	localparam int CFG_IDX_W = 1;
	localparam int KEY_PART_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW = 1'b1;

	typedef struct packed {
		logic [127:0] state;
		logic [127:0] rkey;
	} pipe_t;

	localparam logic [7:0] RCON [0:NUM_ROUNDS] = '{
		8'h8d, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
		8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
	};

	localparam logic [3:0] ROW_SHIFT [0:15] = '{
		4'd0, 4'd5, 4'd10, 4'd15, 4'd4, 4'd9, 4'd14, 4'd3,
		4'd8, 4'd13, 4'd2, 4'd7, 4'd12, 4'd1, 4'd6, 4'd11
	};

	localparam logic [7:0] SBOX [0:255] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [127:0] sub_shift(input logic [127:0] s);
		logic [127:0] t;
		t = '0;
		for (int i = 0; i < 16; i++) begin
			t[127-8*i -: 8] = SBOX[s[127-8*ROW_SHIFT[i] -: 8]];
		end
		return t;
	endfunction

	function automatic logic [31:0] mix_col(input logic [31:0] c);
		logic [7:0] a0, a1, a2, a3;
		a0 = c[31:24];
		a1 = c[23:16];
		a2 = c[15:8];
		a3 = c[7:0];
		return {
			xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
			a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
			a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
			xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)
		};
	endfunction

	function automatic logic [127:0] mix_columns(input logic [127:0] s);
		logic [127:0] t;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			t[127-32*c -: 32] = mix_col(s[127-32*c -: 32]);
		end
		return t;
	endfunction

	function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3, t;
		w3 = k[31:0];
		t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
		w0 = k[127:96] ^ t;
		w1 = k[95:64] ^ w0;
		w2 = k[63:32] ^ w1;
		w3 = w3 ^ w2;
		return {w0, w1, w2, w3};
	endfunction

endpackage

// ===== rtl/core/aes_key_regs.sv =====
// Key register file written through the configuration port.
module aes_key_regs
	import aes_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [KEY_PART_W-1:0] cfg_data,
	output logic [127:0]          key
);

	logic [KEY_PART_W-1:0] key_high_q;
	logic [KEY_PART_W-1:0] key_low_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_KEY_HIGH: begin
					key_high_q <= cfg_data;
				end
				REG_KEY_LOW: begin
					key_low_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign key = {key_high_q, key_low_q};

endmodule

// ===== rtl/core/aes_round.sv =====
// One cipher round and its round key step, held in one pipeline register.
module aes_round
	import aes_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] rcon,
	input  logic       last,
	input  logic       up_valid,
	input  pipe_t      up_data,
	input  logic       down_ready,
	output logic       ready,
	output logic       valid,
	output pipe_t      data
);

	logic  valid_s1;
	pipe_t data_s1;
	pipe_t next_data;
	logic [127:0] sub_state;
	logic [127:0] round_key;

	always_comb begin
		sub_state = sub_shift(up_data.state);
		round_key = key_next(up_data.rkey, rcon);
		next_data.rkey = round_key;
		next_data.state = (last ? sub_state : mix_columns(sub_state)) ^ round_key;
	end

	assign ready = !valid_s1 || down_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && up_valid) begin
			data_s1 <= next_data;
		end
	end

	assign valid = valid_s1;
	assign data = data_s1;

endmodule

// ===== rtl/core/aes128_block_encrypt_unit.sv =====
// Throughput: one request per cycle; eleven register stages, one for the initial key
// addition and one for each of the ten rounds, each computing its own round key.
// A stalled output holds the pipeline only where stages are full; bubbles collapse.
// Reset clears all stage valid bits and sets both key registers to zero.
module aes128_block_encrypt_unit
	import aes_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [KEY_PART_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [63:0]           block_high,
	input  logic [63:0]           block_low,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [63:0]           cipher_high,
	output logic [63:0]           cipher_low
);

	logic [127:0] key;
	logic  stage_valid [0:NUM_ROUNDS];
	pipe_t stage_data [0:NUM_ROUNDS];
	logic  stage_ready [0:NUM_ROUNDS+1];
	logic  entry_valid_s1;
	pipe_t entry_data_s1;

	aes_key_regs u_key_regs (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.key(key)
	);

	assign stage_ready[0] = !entry_valid_s1 || stage_ready[1];
	assign stage_ready[NUM_ROUNDS+1] = out_ready;
	assign in_ready = stage_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_s1 <= 1'b0;
		end else if (stage_ready[0]) begin
			entry_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stage_ready[0] && in_valid) begin
			entry_data_s1.state <= {block_high, block_low} ^ key;
			entry_data_s1.rkey <= key;
		end
	end

	assign stage_valid[0] = entry_valid_s1;
	assign stage_data[0] = entry_data_s1;

	for (genvar r = 1; r <= NUM_ROUNDS; r++) begin : g_round
		aes_round u_round (
			.clk(clk),
			.arst_n(arst_n),
			.rcon(RCON[r]),
			.last(r == NUM_ROUNDS),
			.up_valid(stage_valid[r-1]),
			.up_data(stage_data[r-1]),
			.down_ready(stage_ready[r+1]),
			.ready(stage_ready[r]),
			.valid(stage_valid[r]),
			.data(stage_data[r])
		);
	end

	assign out_valid = stage_valid[NUM_ROUNDS];
	assign cipher_high = stage_data[NUM_ROUNDS].state[127:64];
	assign cipher_low = stage_data[NUM_ROUNDS].state[63:0];

`ifndef SYNTHESIS
	// The entry stage refuses a request only when it is holding one.
	assert property (@(posedge clk) disable iff (!arst_n) !in_ready |-> entry_valid_s1)
		else $error("input stalled with an empty entry stage");

	// A consumer that takes results lets the whole pipeline advance.
	assert property (@(posedge clk) disable iff (!arst_n) out_ready |-> in_ready)
		else $error("input stalled while output is ready");

	// A full middle stage that cannot advance keeps its request intact.
	assert property (@(posedge clk) disable iff (!arst_n)
		stage_valid[5] && !stage_ready[6] |=> stage_valid[5] && $stable(stage_data[5]))
		else $error("stalled stage lost or changed its request");

	// The entry stage picks up a request whenever it has room.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> entry_valid_s1)
		else $error("accepted request did not enter the pipeline");
`endif

endmodule
